// ===== src/icmp_echo_id_translator_top_assert.svh =====
// Assertion macros for the ICMP echo identifier translator.
// Each macro is active in simulation and expands to nothing in synthesis.
`ifndef ICMP_ECHO_ID_TRANSLATOR_TOP_ASSERT_SVH
`define ICMP_ECHO_ID_TRANSLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ICMPID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ICMPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ICMPID_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ICMPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/icmpid_pkg.sv =====
// ----------------------------------------------------------------------------
// icmpid_pkg
// Shared types and constants of the ICMP echo identifier translator.
// ----------------------------------------------------------------------------
`default_nettype none

package icmpid_pkg;

  localparam int MAP_AW    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] PROTO_ICMP      = 8'd1;
  localparam logic [7:0] TYPE_ECHO_REQ   = 8'd8;
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_PORTSET_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORTSET_MASK  = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic ld_in;
    logic sq_en;
    logic map_clr;
    logic map_wr;
    logic map_rd;
    logic adjust;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_req;
    logic is_rep;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

// ===== src/icmpid_ctrl.sv =====
// ----------------------------------------------------------------------------
// icmpid_ctrl
// Sequencer: table clear after reset, then one word at a time through
// square, table access for echo requests and replies, and checksum adjust.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpid_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire icmpid_pkg::status_t st,
  output icmpid_pkg::cmd_t       cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SQUARE = 6'b000100,
    S_REQ_WR = 6'b001000,
    S_RPL_RD = 6'b010000,
    S_ADJUST = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.map_clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.ld_in  = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.sq_en = 1'b1;
        if (st.is_req)      state_next = S_REQ_WR;
        else if (st.is_rep) state_next = S_RPL_RD;
        else                state_next = S_ADJUST;
      end
      S_REQ_WR: begin
        cmd.map_wr = 1'b1;
        state_next = S_ADJUST;
      end
      S_RPL_RD: begin
        cmd.map_rd = 1'b1;
        state_next = S_ADJUST;
      end
      S_ADJUST: begin
        cmd.adjust = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== src/icmpid_dp.sv =====
// ----------------------------------------------------------------------------
// icmpid_dp
// Datapath: config registers, input word registers, identifier hash,
// 64K x 16 identifier map and incremental checksum update.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpid_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire icmpid_pkg::cmd_t                    cmd,
  output icmpid_pkg::status_t                      st,
  input  wire logic                                cfg_write,
  input  wire logic [icmpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                         cfg_data,
  input  wire logic [7:0]                          ip_protocol,
  input  wire logic [7:0]                          icmp_type,
  input  wire logic [15:0]                         echo_identifier,
  input  wire logic [15:0]                         checksum_in,
  output logic [15:0]                              out_identifier,
  output logic [15:0]                              out_checksum,
  output logic                                     translated
);

  logic [15:0] portset_index, portset_mask;
  logic [7:0]  proto_q, type_q;
  logic [15:0] id_q, cks_q;
  logic [31:0] sq_q;
  logic [15:0] new_id_q, rd_q;
  logic [icmpid_pkg::MAP_AW-1:0] clr_addr;

  logic [15:0] id_map [0:(1 << icmpid_pkg::MAP_AW)-1];

  logic [15:0] hash_id, new_id;
  logic        wr_en;
  logic [icmpid_pkg::MAP_AW-1:0] wr_addr;
  logic [15:0] wr_data;
  logic [16:0] diff, sum;
  logic        nonpos;
  logic [15:0] x1, x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      portset_index <= '0;
      portset_mask  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == icmpid_pkg::REG_PORTSET_INDEX) portset_index <= cfg_data;
      if (cfg_index == icmpid_pkg::REG_PORTSET_MASK)  portset_mask  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.map_clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      proto_q <= ip_protocol;
      type_q  <= icmp_type;
      id_q    <= echo_identifier;
      cks_q   <= checksum_in;
    end
    if (cmd.sq_en)  sq_q     <= {16'd0, id_q} * {16'd0, id_q};
    if (cmd.map_wr) new_id_q <= hash_id;
  end

  assign st.is_req   = (proto_q == icmpid_pkg::PROTO_ICMP) &&
                       (type_q == icmpid_pkg::TYPE_ECHO_REQ);
  assign st.is_rep   = (proto_q == icmpid_pkg::PROTO_ICMP) &&
                       (type_q == icmpid_pkg::TYPE_ECHO_REPLY);
  assign st.clr_last = &clr_addr;

  assign hash_id = portset_index | (sq_q[23:8] & ~portset_mask);

  // identifier map: clear sweep or request write, registered read
  always_comb begin
    wr_en   = cmd.map_clr | cmd.map_wr;
    wr_addr = cmd.map_clr ? clr_addr : hash_id;
    wr_data = cmd.map_clr ? 16'd0 : id_q;
  end

  always_ff @(posedge clk) begin
    if (wr_en)      id_map[wr_addr] <= wr_data;
    if (cmd.map_rd) rd_q <= id_map[id_q];
  end

  // incremental checksum: ~cks - old, borrow or zero result wraps with -1, carry wraps with +1
  assign new_id = st.is_rep ? rd_q : new_id_q;
  assign diff   = {1'b0, ~cks_q} - {1'b0, id_q};
  assign nonpos = diff[16] | (diff == 17'd0);
  assign x1     = nonpos ? (diff[15:0] - 16'd1) : diff[15:0];
  assign sum    = {1'b0, x1} + {1'b0, new_id};
  assign x2     = sum[16] ? (sum[15:0] + 16'd1) : sum[15:0];

  always_ff @(posedge clk) begin
    if (cmd.adjust) begin
      if (st.is_req || st.is_rep) begin
        out_identifier <= new_id;
        out_checksum   <= ~x2;
        translated     <= 1'b1;
      end else begin
        out_identifier <= id_q;
        out_checksum   <= cks_q;
        translated     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/icmp_echo_id_translator_top.sv =====
// ----------------------------------------------------------------------------
// icmp_echo_id_translator_top
// ICMP echo identifier translation with incremental checksum update.
//
//   channel   handshake         payload
//   input     start / busy      ip_protocol, icmp_type, echo_identifier,
//                               checksum_in
//   result    done (1 cycle)    out_identifier, out_checksum, translated
//   config    cfg_write         cfg_index, cfg_data
//
// A word passes from accept through square, one map access (only when
// translated) and checksum adjust to done. The next start is taken in the
// cycle done is shown.
// After reset the 65536-entry map is cleared one entry a cycle: busy stays
// high until the sweep ends; config writes are taken throughout.
// Results cannot be stalled; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_id_translator_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [7:0]                       ip_protocol,
  input  wire logic [7:0]                       icmp_type,
  input  wire logic [15:0]                      echo_identifier,
  input  wire logic [15:0]                      checksum_in,
  output logic                                  done,
  output logic [15:0]                           out_identifier,
  output logic [15:0]                           out_checksum,
  output logic                                  translated,
  input  wire logic                             cfg_write,
  input  wire logic [icmpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data
);

  `include "icmp_echo_id_translator_top_assert.svh"

  icmpid_pkg::cmd_t    cmd;
  icmpid_pkg::status_t st;

  icmpid_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  icmpid_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ip_protocol     (ip_protocol),
    .icmp_type       (icmp_type),
    .echo_identifier (echo_identifier),
    .checksum_in     (checksum_in),
    .out_identifier  (out_identifier),
    .out_checksum    (out_checksum),
    .translated      (translated)
  );

  `ICMPID_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted word not busy")
  `ICMPID_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "done while busy")
  `ICMPID_ASSERT_SAME(a_done_after_work, clk, rst, done, $past(busy), "done without work")

endmodule

`default_nettype wire
